/* rtl/pru_pkg.sv */
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, field layouts and defaults for the palette RGB565 upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  // Default values for the top level parameters.
  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_MAX_HEIGHT    = 1024;
  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int DEF_MAX_SCALE     = 4;

  // The job queue between the front and the back end.
  localparam int QUEUE_DEPTH = 8;

  // Fixed field widths.
  localparam int ADDR_W      = 24;
  localparam int COLOUR_W    = 16;
  localparam int COORD_W     = 10;
  localparam int SLOT_W      = 8;
  localparam int SCALE_REG_W = 3;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;

  // Register values after reset, before clamping.
  localparam int SCALE_REG_RST = 1;
  localparam int WIDTH_REG_RST = 1024;

  // Item kind carried on the input tuser.
  typedef enum logic {
    FUNC_PALETTE = 1'b0,
    FUNC_PIXEL   = 1'b1
  } pru_func_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 1'b0,
    CFG_WIDTH = 1'b1
  } pru_cfg_idx_t;

  // Input beat layout, entry_slot in the lowest bits and pad at the top.
  typedef struct packed {
    logic [1:0]        pad;
    logic [SLOT_W-1:0] transp_slot;
    logic              transp_enable;
    logic [SLOT_W-1:0] fill_slot;
    logic              fill_enable;
    logic [SLOT_W-1:0] pixel_index;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] src_x;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [SLOT_W-1:0] entry_slot;
  } pru_in_t;

  localparam int IN_DATA_W = $bits(pru_in_t);

  // Output beat layout, destination address in the lowest bits.
  typedef struct packed {
    logic [COLOUR_W-1:0] pixel_value;
    logic [ADDR_W-1:0]   dest_addr;
  } pru_out_t;

  localparam int OUT_DATA_W = $bits(pru_out_t);

  // One upscale job: top-left destination address and its colour.
  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [COLOUR_W-1:0] colour;
  } pru_job_t;

  // RGB888 to RGB565, keeping the top bits of each channel.
  function automatic logic [COLOUR_W-1:0] rgb888_to_565(input logic [7:0] r,
                                                       input logic [7:0] g,
                                                       input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* rtl/pru_front.sv */
// ----------------------------------------------------------------------------
// pru_front
// Accepts input beats, keeps the palette memory, drops pixels that write
// nothing and works out the top-left destination address of each pixel.
// ----------------------------------------------------------------------------
module pru_front #(
  parameter int MAX_WIDTH     = pru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = pru_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = pru_pkg::DEF_PALETTE_DEPTH,
  parameter int MAX_SCALE     = pru_pkg::DEF_MAX_SCALE,
  parameter int QUEUE_DEPTH   = pru_pkg::QUEUE_DEPTH
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  input  logic [pru_pkg::IN_DATA_W-1:0]                     in_tdata,
  input  logic                                              in_tuser,
  input  logic [$clog2(MAX_SCALE+1)-1:0]                    scale_eff,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                    width_eff,
  input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_SCALE+1)-1:0] ow,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]                  q_count,
  output logic                                              push,
  output pru_pkg::pru_job_t                                 push_job
);
  import pru_pkg::*;

  localparam int SW = $clog2(MAX_SCALE+1);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int OW = WW + SW;
  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int RW = COORD_W + SW;
  localparam int MW = RW + OW;

  pru_in_t             item;
  logic                accept;
  logic                is_pixel;
  logic                outside;
  logic                transparent;
  logic                keep;
  logic                wr_en;
  logic [SLOT_W-1:0]   rd_slot;

  logic [COLOUR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOUR_W-1:0] rd_data_r;

  logic                s1_vld_r;
  logic [COORD_W-1:0]  s1_x_r;
  logic [COORD_W-1:0]  s1_y_r;
  logic                s1_oob_r;

  logic                s2_vld_r;
  logic [RW-1:0]       s2_row_r;
  logic [RW-1:0]       s2_col_r;
  logic [COLOUR_W-1:0] s2_colour_r;

  logic                s3_vld_r;
  pru_job_t            s3_job_r;

  // Classify the beat on the input side.
  assign item        = pru_in_t'(in_tdata);
  assign accept      = in_tvalid && in_tready;
  assign is_pixel    = (pru_func_t'(in_tuser) == FUNC_PIXEL);
  assign outside     = (int'(item.src_x) >= int'(width_eff)) ||
                       (int'(item.src_y) >= MAX_HEIGHT);
  assign transparent = !item.fill_enable && item.transp_enable &&
                       (item.pixel_index == item.transp_slot);
  assign keep        = accept && is_pixel && !outside && !transparent;
  assign wr_en       = accept && !is_pixel && (int'(item.entry_slot) < PALETTE_DEPTH);
  assign rd_slot     = item.fill_enable ? item.fill_slot : item.pixel_index;

  // Take a beat only when the queue has room for everything in flight.
  assign in_tready = (int'(q_count) + int'(s1_vld_r) + int'(s2_vld_r) +
                      int'(s3_vld_r)) < QUEUE_DEPTH;

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[item.entry_slot[PW-1:0]] <= rgb888_to_565(item.red, item.green, item.blue);
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      rd_data_r <= pal_mem[rd_slot[PW-1:0]];
    end
  end

  // Stage one: hold the coordinates while the palette is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      s1_x_r   <= item.src_x;
      s1_y_r   <= item.src_y;
      s1_oob_r <= (int'(rd_slot) >= PALETTE_DEPTH);
    end
  end

  // Stage two: scale the coordinates and pick up the colour.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_row_r    <= RW'(s1_y_r) * RW'(scale_eff);
      s2_col_r    <= RW'(s1_x_r) * RW'(scale_eff);
      s2_colour_r <= s1_oob_r ? '0 : rd_data_r;
    end
  end

  // Stage three: top-left address of the upscaled block, wrapped to 24 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_job_r.base   <= ADDR_W'(MW'(s2_row_r) * MW'(ow)) + ADDR_W'(s2_col_r);
      s3_job_r.colour <= s2_colour_r;
    end
  end

  assign push     = s3_vld_r;
  assign push_job = s3_job_r;

endmodule

/* rtl/pru_queue.sv */
// ----------------------------------------------------------------------------
// pru_queue
// Short job queue that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module pru_queue #(
  parameter int DEPTH = pru_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  pru_pkg::pru_job_t            push_job,
  input  logic                         pop,
  output logic                         head_vld,
  output pru_pkg::pru_job_t            head_job,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import pru_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  pru_job_t       entries [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  // Storage: written at the tail, read at the head.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign head_vld = (count_r != '0);
  assign head_job = entries[rd_ptr_r];
  assign count    = count_r;

`ifndef SYNTH
  // The front end only pushes when its credit check saw room.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (int'(count_r) < DEPTH) || pop)
    else $error("job queue overflow");

  // The back end only pops a job that is there.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("job queue underflow");
`endif

endmodule

/* rtl/pru_back.sv */
// ----------------------------------------------------------------------------
// pru_back
// Walks each upscaled block row by row and sends one destination write per
// cycle through an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module pru_back #(
  parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              q_vld,
  input  pru_pkg::pru_job_t                                 q_job,
  output logic                                              q_pop,
  input  logic [$clog2(MAX_SCALE+1)-1:0]                    scale_eff,
  input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_SCALE+1)-1:0] ow,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  output logic [pru_pkg::OUT_DATA_W-1:0]                    out_tdata,
  output logic                                              out_tlast
);
  import pru_pkg::*;

  localparam int SW = $clog2(MAX_SCALE+1);

  logic                busy_r;
  logic [ADDR_W-1:0]   row_r;
  logic [SW-1:0]       dx_r;
  logic [SW-1:0]       dy_r;
  logic [COLOUR_W-1:0] colour_r;

  logic                out_vld_r;
  pru_out_t            out_data_r;
  logic                out_last_r;

  logic                load_ok;
  logic                emit;
  logic                row_end;
  logic                blk_end;

  // While busy, a beat is made whenever the output register is free or draining.
  assign load_ok = !out_vld_r || out_tready;
  assign emit    = busy_r && load_ok;
  assign row_end = (dx_r == scale_eff - SW'(1));
  assign blk_end = row_end && (dy_r == scale_eff - SW'(1));
  assign q_pop   = q_vld && (!busy_r || (emit && blk_end));

  // Block walker: column counter inside, row counter outside.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
    end else if (emit && blk_end) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      row_r    <= q_job.base;
      colour_r <= q_job.colour;
      dx_r     <= '0;
      dy_r     <= '0;
    end else if (emit) begin
      if (row_end) begin
        dx_r  <= '0;
        dy_r  <= dy_r + SW'(1);
        row_r <= row_r + ADDR_W'(ow);
      end else begin
        dx_r <= dx_r + SW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.dest_addr   <= row_r + ADDR_W'(dx_r);
      out_data_r.pixel_value <= colour_r;
      out_last_r             <= blk_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // The walk counters stay inside the block while a job is active.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (dx_r < scale_eff) && (dy_r < scale_eff))
    else $error("block walk counter out of range");

  // Finishing a block with nothing queued leaves the walker idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && blk_end && !q_vld) |=> !busy_r)
    else $error("walker stayed busy after its last beat");
`endif

endmodule

/* rtl/palette_rgb565_upscaler.sv */
// ----------------------------------------------------------------------------
// palette_rgb565_upscaler
// Palette-indexed pixel writer with integer upscaling to RGB565 writes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat carries
//  in_      slave      tuser: func; tdata: palette write or pixel fields
//  out_     master     tdata: dest_addr, pixel_value; tlast: last_write
//  cfg_     slave      cfg_index: register number; cfg_data: value
//
//  A pixel item produces scale*scale output beats (1 to 16 at the default
//  MAX_SCALE), one per cycle while the output is not stalled; palette writes
//  and pixels that write nothing take one input beat and produce no output.
//  A pixel's first write passes the front stages, the job queue and the walker.
//  Reset clears control state only; the palette is not cleared and an entry
//  must be written before it is used.
//  An output stall holds the output register; the eight-entry job queue lets
//  the input keep accepting until it fills.
// ----------------------------------------------------------------------------
module palette_rgb565_upscaler #(
  parameter int MAX_WIDTH     = pru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = pru_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = pru_pkg::DEF_PALETTE_DEPTH,
  parameter int MAX_SCALE     = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input: tuser = func
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: entry_slot, red, green, blue, src_x, src_y, pixel_index,
  //        fill_enable, fill_slot, transp_enable, transp_slot, zero pad
  input  logic [pru_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  // Output: tdata = dest_addr, pixel_value; tlast = last_write
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pru_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pru_pkg::*;

  localparam int SW = $clog2(MAX_SCALE+1);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int OW = WW + SW;
  localparam int CW = $clog2(QUEUE_DEPTH+1);
  localparam int SCALE_RST = (SCALE_REG_RST > MAX_SCALE) ? MAX_SCALE : SCALE_REG_RST;
  localparam int WIDTH_RST = (WIDTH_REG_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_REG_RST;

  logic [SW-1:0]          scale_eff_r;
  logic [WW-1:0]          width_eff_r;
  logic [OW-1:0]          ow_r;
  logic [SW-1:0]          scale_clamp;
  logic [WW-1:0]          width_clamp;
  logic [SCALE_REG_W-1:0] scale_raw;
  logic [WIDTH_REG_W-1:0] width_raw;

  logic                   push;
  pru_job_t               push_job;
  logic                   q_pop;
  logic                   q_vld;
  pru_job_t               q_job;
  logic [CW-1:0]          q_count;

  // Configuration registers hold the clamped values.
  assign cfg_ready = 1'b1;
  assign scale_raw = cfg_data[SCALE_REG_W-1:0];
  assign width_raw = cfg_data[WIDTH_REG_W-1:0];

  always_comb begin
    if (scale_raw == '0) begin
      scale_clamp = SW'(1);
    end else if (int'(scale_raw) > MAX_SCALE) begin
      scale_clamp = SW'(MAX_SCALE);
    end else begin
      scale_clamp = SW'(scale_raw);
    end
    if (width_raw == '0) begin
      width_clamp = WW'(1);
    end else if (int'(width_raw) > MAX_WIDTH) begin
      width_clamp = WW'(MAX_WIDTH);
    end else begin
      width_clamp = WW'(width_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_eff_r <= SW'(SCALE_RST);
      width_eff_r <= WW'(WIDTH_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (pru_cfg_idx_t'(cfg_index))
        CFG_SCALE: scale_eff_r <= scale_clamp;
        CFG_WIDTH: width_eff_r <= width_clamp;
        default: begin
        end
      endcase
    end
  end

  // Output row pitch, registered off the configuration.
  always_ff @(posedge clk) begin
    ow_r <= OW'(scale_eff_r) * OW'(width_eff_r);
  end

  pru_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_SCALE     (MAX_SCALE),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .scale_eff (scale_eff_r),
    .width_eff (width_eff_r),
    .ow        (ow_r),
    .q_count   (q_count),
    .push      (push),
    .push_job  (push_job)
  );

  pru_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_vld (q_vld),
    .head_job (q_job),
    .count    (q_count)
  );

  pru_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .scale_eff  (scale_eff_r),
    .ow         (ow_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
